@@ rtl/pm_pkg.sv @@
// ----------------------------------------------------------------------------
// pm_pkg
// Shared widths and limits for the polyline metrics block.
// ----------------------------------------------------------------------------
package pm_pkg;

	localparam int COORD_W    = 24;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int SQ_W       = PROD_W + 2;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int TERM_W     = PROD_W + 2;
	localparam int LEN_W      = 37;
	localparam int CROSS_W    = 61;
	localparam int AREA_W     = 59;
	localparam int MAX_POINTS = 4096;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CLOSE_MIN  = 3;
	localparam int STEP_W     = $clog2(ROOT_W);
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 208;

endpackage

@@ rtl/pm_mul.sv @@
// ----------------------------------------------------------------------------
// pm_mul
// Bit-serial unsigned multiplier, one multiplier bit per step.
// ----------------------------------------------------------------------------
module pm_mul import pm_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [COORD_W-1:0] a,
	input  logic [COORD_W-1:0] b,
	output logic [PROD_W-1:0]  prod
);

	logic [COORD_W-1:0] a_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COORD_W:0]   sum;

	// upper half accumulates, lower half shifts the multiplier out
	assign sum  = {1'b0, prod_q[PROD_W-1:COORD_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
	assign prod = prod_q;

	always_ff @(posedge clk) begin
		if (load) begin
			a_q    <= a;
			prod_q <= {{COORD_W{1'b0}}, b};
		end else if (step) begin
			prod_q <= {sum, prod_q[COORD_W-1:1]};
		end
	end

endmodule

@@ rtl/pm_isqrt.sv @@
// ----------------------------------------------------------------------------
// pm_isqrt
// Restoring integer square root, one result bit per step.
// ----------------------------------------------------------------------------
module pm_isqrt import pm_pkg::*; (
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [SQ_W-1:0]   n,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0]   n_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0]  r2;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              ge;

	assign r2    = {rem_q, n_q[SQ_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r2 >= trial);
	assign diff  = r2 - trial;
	assign root  = root_q;

	always_ff @(posedge clk) begin
		if (load) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			n_q    <= {n_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

@@ rtl/polyline_metrics.sv @@
// ----------------------------------------------------------------------------
// polyline_metrics
// Streaming length, bounding box and shoelace area of one polyline.
// ----------------------------------------------------------------------------
// Vertices come in one word at a time as signed 16.8 points, the final one
// flagged by s_tlast; that word produces one result word on the master side.
// Each vertex after the first is accepted and then goes through the
// bit-serial multipliers (dx*dx, dy*dy and the two cross products run side
// by side), a step that forms the sum of squares and the cross term, the
// one-bit-per-step square root, and a step that updates the running sums.
// The first vertex of a polyline goes from accept straight to the update,
// and the final vertex then loads the result register. A new vertex is
// taken only when idle. The result register lets the next polyline start while
// a result still waits on m_tready. Length is the sum of truncated segment
// roots (8 fraction bits, saturating); area is |cross sum| with LSB 2^-17,
// zero unless at least three vertices were seen and the last equals the
// first. The count saturates at 4096 and sets overflow beyond that.
// ----------------------------------------------------------------------------
module polyline_metrics import pm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // x_coord[23:0], y_coord[47:24]
	input  logic                s_tlast,  // last_vertex
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // total_length[36:0], enclosed_area[95:37],
	                                      // min_x[119:96], min_y[143:120],
	                                      // max_x[167:144], max_y[191:168],
	                                      // is_closed[192], point_count[205:193],
	                                      // overflow[206], zero[207]
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_PREP = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_UPD  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q;

	logic [STEP_W-1:0]  step_q;
	logic               first_q;
	logic               last_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic [LEN_W-1:0]   len_q;
	logic [CROSS_W-1:0] cross_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [TERM_W-1:0]  term_q;
	logic               s1_q, s2_q;
	logic               m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	logic               accept;
	logic [COORD_W-1:0] in_x, in_y;
	logic [COORD_W:0]   dx_raw, dy_raw;
	logic [COORD_W:0]   dx_neg, dy_neg;
	logic [COORD_W-1:0] dx_abs, dy_abs;
	logic [COORD_W-1:0] ax_abs, ay_abs, px_abs, py_abs;
	logic               mul_load, mul_step, sq_load, sq_step;
	logic [PROD_W-1:0]  sqx, sqy, p1, p2;
	logic [SQ_W-1:0]    sq_sum;
	logic [ROOT_W-1:0]  root;
	logic [TERM_W-1:0]  p1s, p2s;
	logic [LEN_W:0]     len_sum;
	logic [CROSS_W:0]   cross_sum;
	logic [CROSS_W-1:0] cross_mag;
	logic [AREA_W-1:0]  area;
	logic               closed;
	logic               emit_go;

	assign in_x   = s_tdata[COORD_W-1:0];
	assign in_y   = s_tdata[2*COORD_W-1:COORD_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// segment deltas, as magnitudes
	assign dx_raw = {in_x[COORD_W-1], in_x} - {prev_x_q[COORD_W-1], prev_x_q};
	assign dy_raw = {in_y[COORD_W-1], in_y} - {prev_y_q[COORD_W-1], prev_y_q};
	assign dx_neg = -dx_raw;
	assign dy_neg = -dy_raw;
	assign dx_abs = dx_raw[COORD_W] ? dx_neg[COORD_W-1:0] : dx_raw[COORD_W-1:0];
	assign dy_abs = dy_raw[COORD_W] ? dy_neg[COORD_W-1:0] : dy_raw[COORD_W-1:0];

	// cross products run on magnitudes, signs kept aside
	assign ax_abs = in_x[COORD_W-1] ? -in_x : in_x;
	assign ay_abs = in_y[COORD_W-1] ? -in_y : in_y;
	assign px_abs = prev_x_q[COORD_W-1] ? -prev_x_q : prev_x_q;
	assign py_abs = prev_y_q[COORD_W-1] ? -prev_y_q : prev_y_q;

	assign mul_load = accept && (count_q != '0);
	assign mul_step = (state_q == ST_MUL);
	assign sq_load  = (state_q == ST_PREP);
	assign sq_step  = (state_q == ST_SQRT);

	pm_mul u_mul_dx (.clk(clk), .load(mul_load), .step(mul_step),
		.a(dx_abs), .b(dx_abs), .prod(sqx));
	pm_mul u_mul_dy (.clk(clk), .load(mul_load), .step(mul_step),
		.a(dy_abs), .b(dy_abs), .prod(sqy));
	pm_mul u_mul_p1 (.clk(clk), .load(mul_load), .step(mul_step),
		.a(px_abs), .b(ay_abs), .prod(p1));
	pm_mul u_mul_p2 (.clk(clk), .load(mul_load), .step(mul_step),
		.a(ax_abs), .b(py_abs), .prod(p2));

	assign sq_sum = {2'b00, sqx} + {2'b00, sqy};

	pm_isqrt u_isqrt (.clk(clk), .load(sq_load), .step(sq_step),
		.n(sq_sum), .root(root));

	assign p1s = s1_q ? -{2'b00, p1} : {2'b00, p1};
	assign p2s = s2_q ? -{2'b00, p2} : {2'b00, p2};

	// running sums with saturation
	assign len_sum   = {1'b0, len_q} + {{(LEN_W + 1 - ROOT_W){1'b0}}, root};
	assign cross_sum = {cross_q[CROSS_W-1], cross_q}
		+ {{(CROSS_W + 1 - TERM_W){term_q[TERM_W-1]}}, term_q};

	// result
	assign cross_mag = cross_q[CROSS_W-1] ? -cross_q : cross_q;
	assign area = (cross_mag[CROSS_W-1:AREA_W] != '0) ? {AREA_W{1'b1}}
		: cross_mag[AREA_W-1:0];
	assign closed = (count_q >= CNT_W'(CLOSE_MIN)) && (x_q == first_x_q)
		&& (y_q == first_y_q);
	assign emit_go = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			len_q     <= '0;
			cross_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// result word: load on emit, drop once taken
			if (emit_go)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= (count_q == '0) ? ST_UPD : ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_W'(COORD_W - 1))
						state_q <= ST_PREP;
					step_q <= step_q + 1'b1;
				end
				ST_PREP: begin
					step_q  <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(ROOT_W - 1))
						state_q <= ST_UPD;
					step_q <= step_q + 1'b1;
				end
				ST_UPD: begin
					if (!first_q) begin
						len_q <= len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
						case (cross_sum[CROSS_W:CROSS_W-1])
							2'b01:   cross_q <= {1'b0, {(CROSS_W - 1){1'b1}}};
							2'b10:   cross_q <= {1'b1, {(CROSS_W - 1){1'b0}}};
							default: cross_q <= cross_sum[CROSS_W-1:0];
						endcase
					end
					if (count_q < CNT_W'(MAX_POINTS))
						count_q <= count_q + 1'b1;
					else
						ovf_q <= 1'b1;
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_go) begin
						count_q   <= '0;
						ovf_q     <= 1'b0;
						len_q     <= '0;
						cross_q   <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= in_x;
			y_q     <= in_y;
			last_q  <= s_tlast;
			first_q <= (count_q == '0);
			s1_q    <= prev_x_q[COORD_W-1] ^ in_y[COORD_W-1];
			s2_q    <= in_x[COORD_W-1] ^ prev_y_q[COORD_W-1];
		end
		if (state_q == ST_PREP)
			term_q <= p1s - p2s;
		if (state_q == ST_UPD) begin
			prev_x_q <= x_q;
			prev_y_q <= y_q;
			if (first_q) begin
				first_x_q <= x_q;
				first_y_q <= y_q;
				min_x_q   <= x_q;
				max_x_q   <= x_q;
				min_y_q   <= y_q;
				max_y_q   <= y_q;
			end else begin
				if ($signed(x_q) < $signed(min_x_q)) min_x_q <= x_q;
				if ($signed(y_q) < $signed(min_y_q)) min_y_q <= y_q;
				if ($signed(x_q) > $signed(max_x_q)) max_x_q <= x_q;
				if ($signed(y_q) > $signed(max_y_q)) max_y_q <= y_q;
			end
		end
		if (emit_go)
			m_data_q <= {1'b0, ovf_q, count_q, closed, max_y_q, max_x_q, min_y_q,
				min_x_q, (closed ? area : {AREA_W{1'b0}}), len_q};
	end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking stream test of the polyline metrics block.
// ----------------------------------------------------------------------------
// Vertex words go in on the slave side with random gaps. A scoreboard class
// predicts each polyline result from the accepted words and checks every
// result word on the master side against the oldest prediction. The run has
// a directed part, random polylines, one long receiver hold-off, one drain
// pause, and a final part with no idling.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pm_pkg::*;

	class polyline_scoreboard;
		typedef struct packed {
			logic                      ovf;
			logic [CNT_W-1:0]          cnt;
			logic                      closed;
			logic signed [COORD_W-1:0] max_y;
			logic signed [COORD_W-1:0] max_x;
			logic signed [COORD_W-1:0] min_y;
			logic signed [COORD_W-1:0] min_x;
			logic [AREA_W-1:0]         area;
			logic [LEN_W-1:0]          length;
		} metrics_t;

		metrics_t                  pending[$];
		int                        errors;
		int                        results;
		int                        polylines_long;
		logic signed [COORD_W-1:0] fx, fy, px, py, bx0, by0, bx1, by1;
		logic [LEN_W-1:0]          len_acc;
		logic signed [63:0]        cross_acc;
		int                        count;
		logic                      ovf;

		function new();
			errors = 0;
			results = 0;
			polylines_long = 0;
			clear();
		endfunction

		function void clear();
			fx = 0; fy = 0; px = 0; py = 0;
			bx0 = 0; by0 = 0; bx1 = 0; by1 = 0;
			len_acc = 0;
			cross_acc = 0;
			count = 0;
			ovf = 0;
		endfunction

		static function logic [63:0] int_root(logic [63:0] n);
			logic [63:0] root;
			logic [63:0] bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > n)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= root + bitv) begin
					n = n - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		// Note one accepted vertex word.
		function void note_vertex(logic signed [COORD_W-1:0] x,
		                          logic signed [COORD_W-1:0] y, logic last);
			logic signed [63:0] dx, dy, term;
			logic [63:0]        seg, len_wide;
			metrics_t           m;
			if (count == 0) begin
				fx = x; fy = y;
				bx0 = x; bx1 = x; by0 = y; by1 = y;
			end else begin
				dx = 64'(x) - 64'(px);
				dy = 64'(y) - 64'(py);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				seg = int_root(dx * dx + dy * dy);
				len_wide = 64'(len_acc) + seg;
				len_acc = (len_wide > {LEN_W{1'b1}}) ? {LEN_W{1'b1}} : len_wide[LEN_W-1:0];
				term = 64'(px) * 64'(y) - 64'(x) * 64'(py);
				cross_acc = cross_acc + term;
				if (cross_acc > (64'sd1 <<< 60) - 1) cross_acc = (64'sd1 <<< 60) - 1;
				if (cross_acc < -(64'sd1 <<< 60)) cross_acc = -(64'sd1 <<< 60);
				if (x < bx0) bx0 = x;
				if (y < by0) by0 = y;
				if (x > bx1) bx1 = x;
				if (y > by1) by1 = y;
			end
			px = x; py = y;
			if (count < MAX_POINTS) count++;
			else ovf = 1;
			if (!last)
				return;
			m.closed = (count >= CLOSE_MIN) && x == fx && y == fy;
			m.area = 0;
			if (m.closed) begin
				seg = (cross_acc < 0) ? -cross_acc : cross_acc;
				m.area = (seg > {AREA_W{1'b1}}) ? {AREA_W{1'b1}} : seg[AREA_W-1:0];
			end
			m.length = len_acc;
			m.min_x = bx0; m.min_y = by0; m.max_x = bx1; m.max_y = by1;
			m.cnt = count[CNT_W-1:0];
			m.ovf = ovf;
			if (ovf) polylines_long++;
			pending.push_back(m);
			clear();
		endfunction

		// Check one result word against the oldest prediction.
		function void check_result(logic [M_DATA_W-1:0] word);
			metrics_t got, want;
			got = word[$bits(metrics_t)-1:0];
			results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, word);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (word[M_DATA_W-1] !== 1'b0) begin
				$display("%0t: pad bit expected 0 actual %b", $time, word[M_DATA_W-1]);
				errors++;
			end
			if (got.length !== want.length) begin
				$display("%0t: length expected %0d actual %0d", $time, want.length,
				         got.length);
				errors++;
			end
			if (got.area !== want.area) begin
				$display("%0t: area expected %0d actual %0d", $time, want.area, got.area);
				errors++;
			end
			if (got.min_x !== want.min_x || got.min_y !== want.min_y ||
			    got.max_x !== want.max_x || got.max_y !== want.max_y) begin
				$display("%0t: box expected %0d %0d %0d %0d actual %0d %0d %0d %0d", $time,
				         want.min_x, want.min_y, want.max_x, want.max_y,
				         got.min_x, got.min_y, got.max_x, got.max_y);
				errors++;
			end
			if (got.closed !== want.closed) begin
				$display("%0t: closed expected %b actual %b", $time, want.closed, got.closed);
				errors++;
			end
			if (got.cnt !== want.cnt) begin
				$display("%0t: count expected %0d actual %0d", $time, want.cnt, got.cnt);
				errors++;
			end
			if (got.ovf !== want.ovf) begin
				$display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n = 0;
	logic                s_tvalid = 0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // x_coord[23:0], y_coord[47:24]
	logic                s_tlast = 0;    // last_vertex
	logic                m_tvalid;
	logic                m_tready = 0;
	logic [M_DATA_W-1:0] m_tdata;        // metrics word, see block header

	polyline_scoreboard sb;
	bit                 quiet = 0;      // no idling in the closing part
	bit                 hold_off = 0;   // long receiver stall request
	int                 vertices = 0;

	polyline_metrics u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Send one vertex word; random gap before it unless quiet.
	task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
	                           logic last);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_vertex(x, y, last);
		vertices++;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
		case (mode)
			0: return COORD_W'($urandom());
			1: return COORD_W'($signed(24'($urandom_range(0, 400))) - 200);
			2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return COORD_W'($signed(24'($urandom_range(0, 8000))) - 4000);
		endcase
	endfunction

	// A random polyline: mostly closed ones with random shape.
	task automatic send_polyline(int n);
		logic signed [COORD_W-1:0] x0, y0, x, y;
		int  mode;
		bit  close_it;
		mode = $urandom_range(0, 4);
		close_it = $urandom_range(0, 2) != 0;
		x0 = rand_coord(mode);
		y0 = rand_coord(mode);
		send_vertex(x0, y0, n == 1);
		for (int i = 1; i < n; i++) begin
			x = rand_coord(mode);
			y = rand_coord(mode);
			if (i == n - 1 && close_it) begin
				x = x0; y = y0;
			end
			send_vertex(x, y, i == n - 1);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 14);
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	// Result monitor.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);

	initial begin
		#100ms;
		$display("testbench failed");
		$finish;
	end

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single point, extremes, a unit square, two points
		// equal (not closed), opposite corners for the widest products, a three-point out-and-back.
		send_vertex(24'sh7fffff, 24'sh800000, 1'b1);
		send_vertex(24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd256, 24'sd0, 1'b0);
		send_vertex(24'sd256, 24'sd256, 1'b0);
		send_vertex(24'sd0, 24'sd256, 1'b0);
		send_vertex(24'sd0, 24'sd0, 1'b1);
		send_vertex(24'sd5, 24'sd5, 1'b0);
		send_vertex(24'sd5, 24'sd5, 1'b1);
		send_vertex(24'sh800000, 24'sh800000, 1'b0);
		send_vertex(24'sh7fffff, 24'sh800000, 1'b0);
		send_vertex(24'sh7fffff, 24'sh7fffff, 1'b0);
		send_vertex(24'sh800000, 24'sh7fffff, 1'b0);
		send_vertex(24'sh800000, 24'sh800000, 1'b1);
		send_vertex(-24'sd100, 24'sd7, 1'b0);
		send_vertex(24'sd300, -24'sd9, 1'b0);
		send_vertex(-24'sd100, 24'sd7, 1'b1);
		// Receiver holds off while the sender keeps offering.
		hold_off = 1;
		for (int i = 0; i < 6; i++) send_polyline(2);
		// Pause until every result is in.
		drain();

		for (int k = 0; k < 200; k++) begin
			if (k == 170) quiet = 1;
			if ($urandom_range(0, 9) == 0) send_polyline($urandom_range(1, 2));
			else send_polyline($urandom_range(3, 8));
		end
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d vertex words, checked %0d result words (%0d past the count limit).",
		         vertices, sb.results, sb.polylines_long);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

@@ polyline_metrics.f @@
rtl/pm_pkg.sv
rtl/pm_mul.sv
rtl/pm_isqrt.sv
rtl/polyline_metrics.sv
verif/testbench.sv
